// ===== sv/hdc_pkg.sv =====
// Shared constants, types and helper functions of the haversine distance core.
package hdc_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 24;
  localparam int unsigned CORDIC_W = 34;
  localparam int unsigned SQRT_STAGES = 31;

  localparam int unsigned LAT_W = 28;
  localparam int unsigned LON_W = 29;
  localparam int unsigned DIST_W = 23;
  localparam int unsigned RADIUS_W = 13;
  localparam int unsigned MIN_DIST_W = 15;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic signed [28:0] ANG_MUL = 29'sd190887452;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [30:0] PI_Q29 = 31'd1686629713;
  localparam logic [60:0] ONE_Q60 = 61'h1000_0000_0000_0000;
  localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic [DIST_W-1:0] DIST_MAX = 23'h7FFFFF;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 13'd6371;
  localparam logic [MIN_DIST_W-1:0] MIN_DIST_RST = 15'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS   = 1'b0,
    CFG_MIN_DIST = 1'b1
  } cfg_reg_e;

  function automatic logic [31:0] atan_val(input int unsigned i);
    logic [31:0] v;
    case (i)
      0: v = 32'd536870912;
      1: v = 32'd316933406;
      2: v = 32'd167458907;
      3: v = 32'd85004756;
      4: v = 32'd42667331;
      5: v = 32'd21354465;
      6: v = 32'd10679838;
      7: v = 32'd5340245;
      8: v = 32'd2670163;
      9: v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [CORDIC_W-1:0] quad_sin(
    input logic [1:0] q,
    input logic signed [CORDIC_W-1:0] x,
    input logic signed [CORDIC_W-1:0] y
  );
    logic signed [CORDIC_W-1:0] s;
    case (q)
      2'd0: s = y;
      2'd1: s = x;
      2'd2: s = -y;
      default: s = -x;
    endcase
    return s;
  endfunction

  function automatic logic signed [CORDIC_W-1:0] quad_cos(
    input logic [1:0] q,
    input logic signed [CORDIC_W-1:0] x,
    input logic signed [CORDIC_W-1:0] y
  );
    logic signed [CORDIC_W-1:0] c;
    case (q)
      2'd0: c = x;
      2'd1: c = -y;
      2'd2: c = -x;
      default: c = y;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/hdc_pair_if.sv =====
// Handshake channel that carries one pair of points.
interface hdc_pair_if;
  import hdc_pkg::*;
  logic valid;
  logic ready;
  logic signed [LAT_W-1:0] first_latitude;
  logic signed [LON_W-1:0] first_longitude;
  logic signed [LAT_W-1:0] second_latitude;
  logic signed [LON_W-1:0] second_longitude;
  modport source(output valid, first_latitude, first_longitude, second_latitude,
                 second_longitude, input ready);
  modport sink(input valid, first_latitude, first_longitude, second_latitude,
               second_longitude, output ready);
endinterface

// ===== sv/hdc_dist_if.sv =====
// Handshake channel that carries one distance word.
interface hdc_dist_if;
  import hdc_pkg::*;
  logic valid;
  logic ready;
  logic [DIST_W-1:0] distance_fixed;
  logic below_minimum;
  modport source(output valid, distance_fixed, below_minimum, input ready);
  modport sink(input valid, distance_fixed, below_minimum, output ready);
endinterface

// ===== sv/hdc_cordic.sv =====
// Pipelined CORDIC, one iteration per register stage, rotation or vectoring mode.
module hdc_cordic #(
  parameter int unsigned STEPS = hdc_pkg::CORDIC_STEPS_DEF,
  parameter bit VECTOR = 1'b0
) (
  input  logic clk_i,
  input  logic en_i,
  input  logic signed [hdc_pkg::CORDIC_W-1:0] x_i,
  input  logic signed [hdc_pkg::CORDIC_W-1:0] y_i,
  input  logic signed [hdc_pkg::CORDIC_W-1:0] z_i,
  input  logic [1:0] tag_i,
  output logic signed [hdc_pkg::CORDIC_W-1:0] x_o,
  output logic signed [hdc_pkg::CORDIC_W-1:0] y_o,
  output logic signed [hdc_pkg::CORDIC_W-1:0] z_o,
  output logic [1:0] tag_o
);
  import hdc_pkg::*;

  logic signed [CORDIC_W-1:0] x_q [STEPS];
  logic signed [CORDIC_W-1:0] y_q [STEPS];
  logic signed [CORDIC_W-1:0] z_q [STEPS];
  logic [1:0] tag_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CORDIC_W-1:0] xa, ya, za, dx, dy, ang;
    logic [1:0] ta;
    logic rot_pos;
    if (i == 0) begin : g_first
      assign xa = x_i;
      assign ya = y_i;
      assign za = z_i;
      assign ta = tag_i;
    end else begin : g_next
      assign xa = x_q[i-1];
      assign ya = y_q[i-1];
      assign za = z_q[i-1];
      assign ta = tag_q[i-1];
    end
    assign dx = ya >>> i;
    assign dy = xa >>> i;
    assign ang = $signed({2'b00, atan_val(i)});
    assign rot_pos = VECTOR ? (ya < 0) : (za >= 0);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rot_pos) begin
          x_q[i] <= xa - dx;
          y_q[i] <= ya + dy;
          z_q[i] <= za - ang;
        end else begin
          x_q[i] <= xa + dx;
          y_q[i] <= ya - dy;
          z_q[i] <= za + ang;
        end
        tag_q[i] <= ta;
      end
    end
  end

  assign x_o = x_q[STEPS-1];
  assign y_o = y_q[STEPS-1];
  assign z_o = z_q[STEPS-1];
  assign tag_o = tag_q[STEPS-1];
endmodule

// ===== sv/hdc_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
module hdc_isqrt (
  input  logic clk_i,
  input  logic en_i,
  input  logic [60:0] v_i,
  output logic [30:0] root_o
);
  import hdc_pkg::*;

  logic [61:0] v_q [SQRT_STAGES];
  logic [61:0] r_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [61:0] Bit = 62'(1) << (60 - 2 * k);
    logic [61:0] va, ra, trial;
    if (k == 0) begin : g_first
      assign va = {1'b0, v_i};
      assign ra = '0;
    end else begin : g_next
      assign va = v_q[k-1];
      assign ra = r_q[k-1];
    end
    assign trial = ra + Bit;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (va >= trial) begin
          v_q[k] <= va - trial;
          r_q[k] <= (ra >> 1) + Bit;
        end else begin
          v_q[k] <= va;
          r_q[k] <= ra >> 1;
        end
      end
    end
  end

  assign root_o = r_q[SQRT_STAGES-1][30:0];
endmodule

// ===== sv/haversine_distance_core.sv =====
// Top level of the haversine great-circle distance pipeline.
// Throughput: one word per cycle; the pipeline stalls only when its last stage
// and the output register are both full and the output is not taken.
// Reset clears all valid bits and sets the radius to 6371 km and the minimum to 100 km.
module haversine_distance_core #(
  parameter int unsigned CORDIC_STEPS = hdc_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  hdc_pair_if.sink pair_i,
  hdc_dist_if.source dist_o,
  input  logic cfg_we_i,
  input  logic [hdc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [hdc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import hdc_pkg::*;

  localparam int unsigned LAT = 2 * CORDIC_STEPS + 41;
  localparam int unsigned S = CORDIC_STEPS;

  logic [RADIUS_W-1:0] radius_q;
  logic [MIN_DIST_W-1:0] min_q;
  logic [LAT-1:0] vld_q;
  logic en;
  logic out_valid_q;
  logic [DIST_W-1:0] out_dist_q;
  logic out_near_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      min_q <= MIN_DIST_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_RADIUS: radius_q <= cfg_data_i[RADIUS_W-1:0];
        CFG_MIN_DIST: min_q <= cfg_data_i[MIN_DIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign en = !vld_q[LAT-1] || !out_valid_q || dist_o.ready;
  assign pair_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], pair_i.valid};
    end
  end

  // Angle differences and phase conversion.
  logic signed [LAT_W:0] dlat_q;
  logic signed [LON_W:0] dlon_q;
  logic signed [LAT_W-1:0] lat1_q, lat2_q;
  logic signed [63:0] pr_dlat, pr_dlon, pr_lat1, pr_lat2;
  logic [31:0] ph_dlat_q, ph_dlon_q, ph_lat1_q, ph_lat2_q;

  assign pr_dlat = 64'(dlat_q) * 64'(ANG_MUL);
  assign pr_dlon = 64'(dlon_q) * 64'(ANG_MUL);
  assign pr_lat1 = 64'(lat1_q) * 64'(ANG_MUL);
  assign pr_lat2 = 64'(lat2_q) * 64'(ANG_MUL);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dlat_q <= (LAT_W + 1)'(pair_i.second_latitude) - (LAT_W + 1)'(pair_i.first_latitude);
      dlon_q <= (LON_W + 1)'(pair_i.second_longitude) - (LON_W + 1)'(pair_i.first_longitude);
      lat1_q <= pair_i.first_latitude;
      lat2_q <= pair_i.second_latitude;
      ph_dlat_q <= pr_dlat[56:25];
      ph_dlon_q <= pr_dlon[56:25];
      ph_lat1_q <= pr_lat1[55:24];
      ph_lat2_q <= pr_lat2[55:24];
    end
  end

  // Sines and cosines, their products and the clamped haversine term.
  logic signed [CORDIC_W-1:0] rx [4];
  logic signed [CORDIC_W-1:0] ry [4];
  logic signed [CORDIC_W-1:0] rz [4];
  logic [1:0] rq [4];
  logic [31:0] ph [4];

  assign ph[0] = ph_dlat_q;
  assign ph[1] = ph_dlon_q;
  assign ph[2] = ph_lat1_q;
  assign ph[3] = ph_lat2_q;

  for (genvar j = 0; j < 4; j++) begin : g_rot
    hdc_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (CORDIC_GAIN),
      .y_i   ('0),
      .z_i   ($signed({4'b0000, ph[j][29:0]})),
      .tag_i (ph[j][31:30]),
      .x_o   (rx[j]),
      .y_o   (ry[j]),
      .z_o   (rz[j]),
      .tag_o (rq[j])
    );
  end

  logic signed [CORDIC_W-1:0] s1_q, s2_q, c1_q, c2_q;
  logic signed [CORDIC_W-1:0] s2_m1_q, s2_m2_q, p_q, u_q;
  logic signed [63:0] s1sq_q, s1sq_m2_q, s1sq_m3_q, us_q, a_sum;
  logic signed [67:0] m_cc, m_ss, m_ps, m_us;
  logic [60:0] a_q;

  assign m_cc = c1_q * c2_q;
  assign m_ss = s1_q * s1_q;
  assign m_ps = p_q * s2_m1_q;
  assign m_us = u_q * s2_m2_q;
  assign a_sum = s1sq_m3_q + us_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= quad_sin(rq[0], rx[0], ry[0]);
      s2_q <= quad_sin(rq[1], rx[1], ry[1]);
      c1_q <= quad_cos(rq[2], rx[2], ry[2]);
      c2_q <= quad_cos(rq[3], rx[3], ry[3]);
      p_q <= m_cc[63:30];
      s1sq_q <= m_ss[63:0];
      s2_m1_q <= s2_q;
      u_q <= m_ps[63:30];
      s1sq_m2_q <= s1sq_q;
      s2_m2_q <= s2_m1_q;
      us_q <= m_us[63:0];
      s1sq_m3_q <= s1sq_m2_q;
      if (a_sum < 0) begin
        a_q <= '0;
      end else if (a_sum > $signed({3'b000, ONE_Q60})) begin
        a_q <= ONE_Q60;
      end else begin
        a_q <= a_sum[60:0];
      end
    end
  end

  // Square roots and central angle.
  logic [30:0] h_root, g_root;

  hdc_isqrt u_sqrt_h (
    .clk_i  (clk_i),
    .en_i   (en),
    .v_i    (a_q),
    .root_o (h_root)
  );

  hdc_isqrt u_sqrt_g (
    .clk_i  (clk_i),
    .en_i   (en),
    .v_i    (ONE_Q60 - a_q),
    .root_o (g_root)
  );

  logic signed [CORDIC_W-1:0] vx, vy, vz;
  logic [1:0] vtag;

  hdc_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1)) u_vec (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   ($signed({3'b000, g_root})),
    .y_i   ($signed({3'b000, h_root})),
    .z_i   ('0),
    .tag_i (2'b00),
    .x_o   (vx),
    .y_o   (vy),
    .z_o   (vz),
    .tag_o (vtag)
  );

  // Scaling by pi and the radius, rounding and saturation.
  logic [30:0] zc_q;
  logic [40:0] t_q;
  logic [53:0] d_q;
  logic [61:0] m_t;
  logic [54:0] rnd;
  logic [DIST_W-1:0] dist_sat;

  assign m_t = 62'(zc_q) * 62'(PI_Q29);
  assign rnd = {1'b0, d_q} + 55'(32'h2000_0000);
  assign dist_sat = (rnd[54:30] > 25'(DIST_MAX)) ? DIST_MAX : rnd[52:30];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (vz < 0) begin
        zc_q <= '0;
      end else if (vz > QUARTER_TURN) begin
        zc_q <= QUARTER_TURN[30:0];
      end else begin
        zc_q <= vz[30:0];
      end
      t_q <= m_t[61:21];
      d_q <= 54'(radius_q) * 54'(t_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && vld_q[LAT-1]) begin
      out_valid_q <= 1'b1;
    end else if (dist_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[LAT-1]) begin
      out_dist_q <= dist_sat;
      out_near_q <= (dist_sat < {min_q, 8'h00});
    end
  end

  assign dist_o.valid = out_valid_q;
  assign dist_o.distance_fixed = out_dist_q;
  assign dist_o.below_minimum = out_near_q;

  // The vectoring x and y outputs and tag, the rotation z outputs and S are not part of the result.
  logic unused_vec;
  assign unused_vec = ^{vx, vy, vtag, rz[0], rz[1], rz[2], rz[3], S[0]};

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAT-1] && dist_o.valid && !dist_o.ready) |-> !pair_i.ready)
    else $error("Input accepted while the full pipeline was stalled.");

  a_out_from_last_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(dist_o.valid) |-> $past(vld_q[LAT-1]))
    else $error("Output word appeared without a valid last stage.");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pair_i.valid && pair_i.ready) |=> vld_q[0])
    else $error("Accepted pair did not enter the pipeline.");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench of the haversine distance core with random pairs and stalls.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hdc_pkg::*;

  typedef struct packed {
    logic signed [LAT_W-1:0] lat1;
    logic signed [LON_W-1:0] lon1;
    logic signed [LAT_W-1:0] lat2;
    logic signed [LON_W-1:0] lon2;
  } point_pair_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic near;
  } dist_word_t;

  localparam longint LAT_SPAN = 94371840;
  localparam longint LON_SPAN = 188743680;
  localparam int STALL_LIMIT = 5000;
  localparam longint ARCTAN_LUT [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  hdc_pair_if pair_ch ();
  hdc_dist_if dist_ch ();

  haversine_distance_core uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .pair_i(pair_ch.sink),
    .dist_o(dist_ch.source),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  point_pair_t pending_pairs[$];
  dist_word_t expected_dists[$];
  point_pair_t pair_on_bus;
  logic pair_taken = 1'b0;
  longint unsigned radius_km = 6371;
  longint unsigned min_km = 100;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int errors = 0;
  int stall_cycles = 0;

  function automatic logic [31:0] angle_phase(input longint v, input int sh);
    longint unsigned prod;
    prod = v * 64'd190887452;
    return prod[sh +: 32];
  endfunction

  function automatic void rotate_sincos(input logic [31:0] ph, output longint c,
                                        output longint s);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = longint'(ph[29:0]);
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ARCTAN_LUT[i];
      end else begin
        x += dx; y -= dy; z += ARCTAN_LUT[i];
      end
    end
    case (ph[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic dist_word_t great_circle(input point_pair_t pp);
    longint la1, lo1, la2, lo2, s1, s2, c1, c2, dummy, p, u, a, x, y, z, dx, dy;
    longint unsigned t, d;
    dist_word_t w;
    la1 = pp.lat1; lo1 = pp.lon1; la2 = pp.lat2; lo2 = pp.lon2;
    rotate_sincos(angle_phase(la2 - la1, 25), dummy, s1);
    rotate_sincos(angle_phase(lo2 - lo1, 25), dummy, s2);
    rotate_sincos(angle_phase(la1, 24), c1, dummy);
    rotate_sincos(angle_phase(la2, 24), c2, dummy);
    p = (c1 * c2) >>> 30;
    u = (p * s2) >>> 30;
    a = s1 * s1 + u * s2;
    if (a < 0) a = 0;
    if (a > (64'sd1 <<< 60)) a = 64'sd1 <<< 60;
    y = int_sqrt(a);
    x = int_sqrt((64'd1 << 60) - a);
    z = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ARCTAN_LUT[i];
      end else begin
        x -= dx; y += dy; z -= ARCTAN_LUT[i];
      end
    end
    if (z < 0) z = 0;
    if (z > (64'sd1 <<< 30)) z = 64'sd1 <<< 30;
    t = (longint'(z) * 64'd1686629713) >> 21;
    d = (radius_km * t + (64'd1 << 29)) >> 30;
    if (d > 64'd8388607) d = 64'd8388607;
    w.distance = d[DIST_W-1:0];
    w.near = d < (min_km << 8);
    return w;
  endfunction

  function automatic point_pair_t random_pair();
    point_pair_t pp;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      pp.lat1 = LAT_W'($urandom); pp.lon1 = LON_W'($urandom);
      pp.lat2 = LAT_W'($urandom); pp.lon2 = LON_W'($urandom);
    end else begin
      pp.lat1 = LAT_W'(longint'($urandom_range(0, 32'(2 * LAT_SPAN))) - LAT_SPAN);
      pp.lon1 = LON_W'(longint'($urandom_range(0, 32'(2 * LON_SPAN))) - LON_SPAN);
      if (kind < 45) begin
        pp.lat2 = LAT_W'(pp.lat1 + longint'($urandom_range(0, 2 << 20)) - (1 << 20));
        pp.lon2 = LON_W'(pp.lon1 + longint'($urandom_range(0, 2 << 20)) - (1 << 20));
      end else begin
        pp.lat2 = LAT_W'(longint'($urandom_range(0, 32'(2 * LAT_SPAN))) - LAT_SPAN);
        pp.lon2 = LON_W'(longint'($urandom_range(0, 32'(2 * LON_SPAN))) - LON_SPAN);
      end
    end
    return pp;
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_RADIUS) radius_km = 64'(val[RADIUS_W-1:0]);
    else min_km = 64'(val[MIN_DIST_W-1:0]);
  endtask

  task automatic push_pair(input longint a, input longint b, input longint c,
                           input longint d);
    point_pair_t pp;
    pp.lat1 = LAT_W'(a); pp.lon1 = LON_W'(b); pp.lat2 = LAT_W'(c); pp.lon2 = LON_W'(d);
    pending_pairs.push_back(pp);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pair_ch.valid <= 1'b0;
      dist_ch.ready <= 1'b0;
    end else begin
      if (!pair_ch.valid || pair_taken) begin
        pair_taken = 1'b0;
        if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          pair_on_bus = pending_pairs.pop_front();
          pair_ch.valid <= 1'b1;
          pair_ch.first_latitude <= pair_on_bus.lat1;
          pair_ch.first_longitude <= pair_on_bus.lon1;
          pair_ch.second_latitude <= pair_on_bus.lat2;
          pair_ch.second_longitude <= pair_on_bus.lon2;
        end else begin
          pair_ch.valid <= 1'b0;
        end
      end
      dist_ch.ready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  always @(posedge clk_i) begin
    dist_word_t want;
    logic moved;
    moved = 1'b0;
    if (rst_ni && pair_ch.valid && pair_ch.ready) begin
      expected_dists.push_back(great_circle(pair_on_bus));
      pair_taken = 1'b1;
      moved = 1'b1;
    end
    if (rst_ni && dist_ch.valid && dist_ch.ready) begin
      moved = 1'b1;
      if (expected_dists.size() == 0) begin
        errors++;
        if (errors <= 10) $display("tb: unexpected distance word %0d", dist_ch.distance_fixed);
      end else begin
        want = expected_dists.pop_front();
        if (dist_ch.distance_fixed !== want.distance || dist_ch.below_minimum !== want.near) begin
          errors++;
          if (errors <= 10)
            $display("tb: mismatch dist exp %0d got %0d, near exp %0b got %0b",
                     want.distance, dist_ch.distance_fixed, want.near, dist_ch.below_minimum);
        end
      end
    end
    if (!moved && (pending_pairs.size() != 0 || expected_dists.size() != 0 ||
                   pair_ch.valid)) begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end else begin
      stall_cycles = 0;
    end
  end

  initial begin
    pair_ch.valid = 1'b0;
    pair_ch.first_latitude = '0;
    pair_ch.first_longitude = '0;
    pair_ch.second_latitude = '0;
    pair_ch.second_longitude = '0;
    dist_ch.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_RADIUS;
    cfg_data_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin write_reg(CFG_RADIUS, 15'd8191); write_reg(CFG_MIN_DIST, 15'd32767); end
        2: begin write_reg(CFG_RADIUS, 15'h2000); write_reg(CFG_MIN_DIST, 15'd0); end
        3: begin write_reg(CFG_RADIUS, 15'd1); write_reg(CFG_MIN_DIST, 15'd1); end
        4: begin
          write_reg(CFG_RADIUS, CFG_DATA_W'($urandom_range(1, 8191)));
          write_reg(CFG_MIN_DIST, CFG_DATA_W'($urandom_range(0, 32767)));
        end
        5: begin write_reg(CFG_RADIUS, 15'd6371); write_reg(CFG_MIN_DIST, 15'd100); end
        default: ;
      endcase
      send_idle_pct = (ph < 2) ? 13 : (ph < 4) ? 50 : 0;
      recv_idle_pct = (ph < 2) ? 50 : (ph < 4) ? 13 : 0;
      if (ph == 0) begin
        push_pair(0, 0, 0, 0);
        push_pair(LAT_SPAN, LON_SPAN, LAT_SPAN, LON_SPAN);
        push_pair(-LAT_SPAN, -LON_SPAN, LAT_SPAN, LON_SPAN);
        push_pair(LAT_SPAN, 0, -LAT_SPAN, 0);
        push_pair(0, 0, 0, LON_SPAN);
        push_pair(0, -LON_SPAN, 0, LON_SPAN);
        push_pair(-(1 << 27), -(1 << 28), (1 << 27) - 1, (1 << 28) - 1);
        push_pair((1 << 27) - 1, (1 << 28) - 1, -(1 << 27), -(1 << 28));
        push_pair(-1, -1, -1, -1);
        push_pair(0, 0, 1, 1);
        push_pair(0, 0, 1 << 20, 0);
        push_pair(123456789, 0, 0, 0);
        push_pair(45 << 20, 90 << 20, -(45 << 20), -(90 << 20));
        push_pair(30 << 20, 10 << 20, 30 << 20, 11 << 20);
        push_pair(-(60 << 20), 170 << 20, -(60 << 20), -(170 << 20));
        push_pair(LAT_SPAN, 55 << 20, LAT_SPAN, -(125 << 20));
        push_pair(10 << 20, 20 << 20, (10 << 20) + 500000, (20 << 20) - 500000);
        push_pair(-(1 << 27), 0, -(1 << 27), 0);
        push_pair(0, (1 << 28) - 1, 0, -(1 << 28));
      end
      for (int k = 0; k < 140; k++) pending_pairs.push_back(random_pair());
      wait (pending_pairs.size() == 0 && expected_dists.size() == 0 && !pair_ch.valid);
      repeat (100) @(negedge clk_i);
    end

    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

// ===== haversine_distance_core.f =====
sv/hdc_pkg.sv
sv/hdc_pair_if.sv
sv/hdc_dist_if.sv
sv/hdc_cordic.sv
sv/hdc_isqrt.sv
sv/haversine_distance_core.sv
verif/tb.sv
